### rtl/sctp_hcp_pkg.sv
package sctp_hcp_pkg;

   localparam int MAX_PACKET_BYTES    = 65535;
   localparam int COMMON_HEADER_BYTES = 12;
   localparam int CHUNK_HEADER_BYTES  = 4;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW            = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_CHUNK     = 2'd0,
      KIND_SUMMARY   = 2'd1,
      KIND_TOO_SHORT = 2'd2
   } result_kind_type;

   typedef enum logic [3:0] {
      PH_COMMON     = 4'b0001,
      PH_CHUNK_HDR  = 4'b0010,
      PH_CHUNK_BODY = 4'b0100,
      PH_STOPPED    = 4'b1000
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  desc_type;
      logic [7:0]  desc_flags;
      logic [15:0] desc_length;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [31:0] verify_tag;
      logic [31:0] packet_checksum;
      logic [13:0] chunks_found;
      logic [15:0] payload_total;
      logic [15:0] header_total;
      logic        last_result;
   } rsp_type;

endpackage

### rtl/sctp_header_chunk_parser_top.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    sctp_hcp_pkg::req_type (one packet byte)
// rsp       out        rsp_valid/stall    sctp_hcp_pkg::rsp_type (descriptor or summary)
//
// While req_stall is low, one byte is taken per cycle; its results enter a four-entry
// result queue on the same edge, and rsp shows the oldest result in the queue.
// A byte yields up to two results; the queue drains one per cycle while rsp_stall is low.
// req_stall is high while three or more results wait in the queue.
// Synchronous reset clears the parser state and empties the queue.
module sctp_header_chunk_parser_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sctp_hcp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sctp_hcp_pkg::rsp_type rsp_data
);

   sctp_hcp_pkg::parse_phase_type phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] port_ff, port_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] csum_ff, csum_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [15:0] left_ff, left_in;
   logic [13:0] chunks_ff, chunks_in;
   logic [15:0] lsum_ff, lsum_in;

   sctp_hcp_pkg::rsp_type queue_ff [sctp_hcp_pkg::QUEUE_DEPTH];
   logic [sctp_hcp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sctp_hcp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sctp_hcp_pkg::QUEUE_CW-1:0] count_ff, count_in;

   logic                  accept;
   logic                  pop;
   logic                  emit;
   logic [15:0]           left_inc;
   logic [15:0]           left_dec;
   logic [15:0]           four_each;
   sctp_hcp_pkg::rsp_type chunk_res;
   sctp_hcp_pkg::rsp_type summary_res;
   sctp_hcp_pkg::rsp_type first_res;
   logic                  push_first;
   logic                  push_second;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > sctp_hcp_pkg::QUEUE_CW'(sctp_hcp_pkg::QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      port_in   = port_ff;
      tag_in    = tag_ff;
      csum_in   = csum_ff;
      hdr_in    = hdr_ff;
      left_in   = left_ff;
      emit      = 1'b0;
      left_inc  = left_ff + 16'd1;
      left_dec  = (left_ff != 16'd0) ? left_ff - 16'd1 : 16'd0;

      if (pos_ff < 16'(sctp_hcp_pkg::MAX_PACKET_BYTES)) begin
         pos_in = pos_ff + 16'd1;
         case (phase_ff)
            sctp_hcp_pkg::PH_COMMON: begin
               if (pos_ff < 16'd4) begin
                  port_in = {port_ff[23:0], req_data.data_byte};
               end else if (pos_ff < 16'd8) begin
                  tag_in = {tag_ff[23:0], req_data.data_byte};
               end else begin
                  csum_in = {csum_ff[23:0], req_data.data_byte};
               end
               if (pos_in >= 16'(sctp_hcp_pkg::COMMON_HEADER_BYTES)) begin
                  phase_in = sctp_hcp_pkg::PH_CHUNK_HDR;
                  left_in  = 16'd0;
               end
            end
            sctp_hcp_pkg::PH_CHUNK_HDR: begin
               hdr_in  = {hdr_ff[23:0], req_data.data_byte};
               left_in = left_inc;
               if (left_inc >= 16'(sctp_hcp_pkg::CHUNK_HEADER_BYTES)) begin
                  if (hdr_in[15:0] < 16'(sctp_hcp_pkg::CHUNK_HEADER_BYTES)) begin
                     phase_in = sctp_hcp_pkg::PH_STOPPED;
                     left_in  = 16'd0;
                  end else if (hdr_in[15:0] == 16'(sctp_hcp_pkg::CHUNK_HEADER_BYTES)) begin
                     emit    = 1'b1;
                     left_in = 16'd0;
                  end else begin
                     phase_in = sctp_hcp_pkg::PH_CHUNK_BODY;
                     left_in  = hdr_in[15:0] - 16'(sctp_hcp_pkg::CHUNK_HEADER_BYTES);
                  end
               end
            end
            sctp_hcp_pkg::PH_CHUNK_BODY: begin
               left_in = left_dec;
               if (left_dec == 16'd0) begin
                  emit     = 1'b1;
                  phase_in = sctp_hcp_pkg::PH_CHUNK_HDR;
               end
            end
            sctp_hcp_pkg::PH_STOPPED: begin
               phase_in = sctp_hcp_pkg::PH_STOPPED;
            end
            default: begin
               phase_in = sctp_hcp_pkg::PH_STOPPED;
            end
         endcase
      end

      chunks_in = emit ? chunks_ff + 14'd1 : chunks_ff;
      lsum_in   = emit ? lsum_ff + hdr_in[15:0] : lsum_ff;
      four_each = {chunks_in, 2'b00};

      chunk_res             = '0;
      chunk_res.result_kind = sctp_hcp_pkg::KIND_CHUNK;
      chunk_res.desc_type   = hdr_in[31:24];
      chunk_res.desc_flags  = hdr_in[23:16];
      chunk_res.desc_length = hdr_in[15:0];
      chunk_res.last_result = !req_data.last_byte;

      summary_res             = '0;
      summary_res.last_result = 1'b1;
      if (pos_in < 16'(sctp_hcp_pkg::COMMON_HEADER_BYTES)) begin
         summary_res.result_kind = sctp_hcp_pkg::KIND_TOO_SHORT;
      end else begin
         summary_res.result_kind      = sctp_hcp_pkg::KIND_SUMMARY;
         summary_res.source_port      = port_in[31:16];
         summary_res.destination_port = port_in[15:0];
         summary_res.verify_tag       = tag_in;
         summary_res.packet_checksum  = csum_in;
         summary_res.chunks_found     = chunks_in;
         summary_res.payload_total    = lsum_in - four_each;
         summary_res.header_total     = lsum_in + 16'(sctp_hcp_pkg::COMMON_HEADER_BYTES);
      end

      first_res   = emit ? chunk_res : summary_res;
      push_first  = accept && (emit || req_data.last_byte);
      push_second = accept && emit && req_data.last_byte;

      // restart for the next packet after the final byte
      if (req_data.last_byte) begin
         phase_in  = sctp_hcp_pkg::PH_COMMON;
         pos_in    = 16'd0;
         port_in   = 32'd0;
         tag_in    = 32'd0;
         csum_in   = 32'd0;
         hdr_in    = 32'd0;
         left_in   = 16'd0;
         chunks_in = 14'd0;
         lsum_in   = 16'd0;
      end

      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + sctp_hcp_pkg::QUEUE_AW'(push_first)
                  + sctp_hcp_pkg::QUEUE_AW'(push_second);
      count_in  = count_ff + sctp_hcp_pkg::QUEUE_CW'(push_first)
                  + sctp_hcp_pkg::QUEUE_CW'(push_second)
                  - sctp_hcp_pkg::QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sctp_hcp_pkg::PH_COMMON;
         pos_ff    <= 16'd0;
         port_ff   <= 32'd0;
         tag_ff    <= 32'd0;
         csum_ff   <= 32'd0;
         hdr_ff    <= 32'd0;
         left_ff   <= 16'd0;
         chunks_ff <= 14'd0;
         lsum_ff   <= 16'd0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            port_ff   <= port_in;
            tag_ff    <= tag_in;
            csum_ff   <= csum_in;
            hdr_ff    <= hdr_in;
            left_ff   <= left_in;
            chunks_ff <= chunks_in;
            lsum_ff   <= lsum_in;
         end
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (push_second) begin
         queue_ff[wr_ptr_ff + 1'b1] <= summary_res;
      end
   end

endmodule

### bench/tb_sctp_scoreboard_pkg.sv
package tb_sctp_scoreboard_pkg;
   import sctp_hcp_pkg::*;

   class sctp_parse_scoreboard;
      bit [15:0]       byte_count;
      parse_phase_type phase;
      bit [31:0]       port_word;
      bit [31:0]       tag_word;
      bit [31:0]       checksum_word;
      bit [31:0]       chunk_head;
      bit [15:0]       chunk_left;
      bit [13:0]       done_chunks;
      bit [15:0]       length_total;
      rsp_type         due_results[$];
      int              mismatches;
      int              results_checked;

      function new();
         clear_state();
         mismatches = 0;
         results_checked = 0;
      endfunction

      function void clear_state();
         byte_count    = '0;
         phase         = PH_COMMON;
         port_word     = '0;
         tag_word      = '0;
         checksum_word = '0;
         chunk_head    = '0;
         chunk_left    = '0;
         done_chunks   = '0;
         length_total  = '0;
      endfunction

      function rsp_type finish_chunk();
         rsp_type r;
         r             = '0;
         r.result_kind = KIND_CHUNK;
         r.desc_type   = chunk_head[31:24];
         r.desc_flags  = chunk_head[23:16];
         r.desc_length = chunk_head[15:0];
         done_chunks   = done_chunks + 14'd1;
         length_total  = length_total + chunk_head[15:0];
         return r;
      endfunction

      function void take_byte(req_type item);
         rsp_type   made[2];
         rsp_type   r;
         int        n;
         bit [15:0] pos;
         bit [15:0] len;
         n = 0;
         if (byte_count < MAX_PACKET_BYTES) begin
            pos        = byte_count;
            byte_count = byte_count + 16'd1;
            case (phase)
               PH_COMMON: begin
                  if (pos < 4)
                     port_word = {port_word[23:0], item.data_byte};
                  else if (pos < 8)
                     tag_word = {tag_word[23:0], item.data_byte};
                  else
                     checksum_word = {checksum_word[23:0], item.data_byte};
                  if (pos + 1 >= COMMON_HEADER_BYTES) begin
                     phase      = PH_CHUNK_HDR;
                     chunk_left = '0;
                  end
               end
               PH_CHUNK_HDR: begin
                  chunk_head = {chunk_head[23:0], item.data_byte};
                  chunk_left = chunk_left + 16'd1;
                  if (chunk_left >= CHUNK_HEADER_BYTES) begin
                     len = chunk_head[15:0];
                     if (len < CHUNK_HEADER_BYTES) begin
                        phase      = PH_STOPPED;
                        chunk_left = '0;
                     end else if (len == CHUNK_HEADER_BYTES) begin
                        made[n]    = finish_chunk();
                        n++;
                        chunk_left = '0;
                     end else begin
                        phase      = PH_CHUNK_BODY;
                        chunk_left = len - 16'(CHUNK_HEADER_BYTES);
                     end
                  end
               end
               PH_CHUNK_BODY: begin
                  if (chunk_left > 0)
                     chunk_left = chunk_left - 16'd1;
                  if (chunk_left == 0) begin
                     made[n] = finish_chunk();
                     n++;
                     phase   = PH_CHUNK_HDR;
                  end
               end
               default: ;
            endcase
         end
         if (item.last_byte) begin
            r = '0;
            if (byte_count < COMMON_HEADER_BYTES) begin
               r.result_kind = KIND_TOO_SHORT;
            end else begin
               r.result_kind      = KIND_SUMMARY;
               r.source_port      = port_word[31:16];
               r.destination_port = port_word[15:0];
               r.verify_tag       = tag_word;
               r.packet_checksum  = checksum_word;
               r.chunks_found     = done_chunks;
               r.payload_total    = length_total - {done_chunks, 2'b00};
               r.header_total     = length_total + 16'(COMMON_HEADER_BYTES);
            end
            made[n] = r;
            n++;
            clear_state();
         end
         if (n > 0)
            made[n - 1].last_result = 1'b1;
         for (int i = 0; i < n; i++)
            due_results.push_back(made[i]);
      endfunction

      task report(string what, bit [31:0] got, bit [31:0] want);
         $display("tb: mismatch on %s: got %h, expected %h", what, got, want);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            report("result with none due", 32'(got.result_kind), '0);
            return;
         end
         want = due_results.pop_front();
         results_checked++;
         if (got.result_kind !== want.result_kind)
            report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
         if (got.desc_type !== want.desc_type)
            report("desc_type", 32'(got.desc_type), 32'(want.desc_type));
         if (got.desc_flags !== want.desc_flags)
            report("desc_flags", 32'(got.desc_flags), 32'(want.desc_flags));
         if (got.desc_length !== want.desc_length)
            report("desc_length", 32'(got.desc_length), 32'(want.desc_length));
         if (got.source_port !== want.source_port)
            report("source_port", 32'(got.source_port), 32'(want.source_port));
         if (got.destination_port !== want.destination_port)
            report("destination_port", 32'(got.destination_port),
                   32'(want.destination_port));
         if (got.verify_tag !== want.verify_tag)
            report("verify_tag", got.verify_tag, want.verify_tag);
         if (got.packet_checksum !== want.packet_checksum)
            report("packet_checksum", got.packet_checksum, want.packet_checksum);
         if (got.chunks_found !== want.chunks_found)
            report("chunks_found", 32'(got.chunks_found), 32'(want.chunks_found));
         if (got.payload_total !== want.payload_total)
            report("payload_total", 32'(got.payload_total), 32'(want.payload_total));
         if (got.header_total !== want.header_total)
            report("header_total", 32'(got.header_total), 32'(want.header_total));
         if (got.last_result !== want.last_result)
            report("last_result", 32'(got.last_result), 32'(want.last_result));
      endtask
   endclass

endpackage

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sctp_hcp_pkg::*;
   import tb_sctp_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sctp_parse_scoreboard sb;
   bit [7:0] packet_bytes[$];
   int       send_gap_pct = 0;
   int       recv_gap_pct = 0;
   int       hold_asked   = 0;
   int       hold_taken   = 0;
   int       hold_left    = 0;
   int       bytes_sent   = 0;
   int       packets_sent = 0;
   int       cycle_count  = 0;

   sctp_header_chunk_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   task drive_byte(bit [7:0] value, bit last);
      req_type item;
      item.data_byte = value;
      item.last_byte = last;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.take_byte(item);
      bytes_sent++;
   endtask

   task send_packet();
      foreach (packet_bytes[i])
         drive_byte(packet_bytes[i], i == packet_bytes.size() - 1);
      packets_sent++;
   endtask

   task wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.due_results.size() != 0);
   endtask

   function void add_random_bytes(int count);
      repeat (count) packet_bytes.push_back(8'($urandom));
   endfunction

   function void add_chunk(bit [15:0] len);
      packet_bytes.push_back(8'($urandom));
      packet_bytes.push_back(8'($urandom));
      packet_bytes.push_back(len[15:8]);
      packet_bytes.push_back(len[7:0]);
      add_random_bytes(int'(len) - CHUNK_HEADER_BYTES);
   endfunction

   function void build_random_packet();
      int pick;
      int chunk_total;
      packet_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 7) begin
         add_random_bytes($urandom_range(1, 11));
         return;
      end
      if (pick < 13) begin
         add_random_bytes($urandom_range(1, 40));
         return;
      end
      add_random_bytes(COMMON_HEADER_BYTES);
      chunk_total = $urandom_range(0, 4);
      repeat (chunk_total)
         add_chunk(16'(($urandom_range(99) < 20) ? 4 : $urandom_range(5, 40)));
      if (pick < 20) begin
         packet_bytes.push_back(8'($urandom));
         packet_bytes.push_back(8'($urandom));
         packet_bytes.push_back(8'h00);
         packet_bytes.push_back(8'($urandom_range(0, 3)));
         add_random_bytes($urandom_range(0, 5));
      end else if (pick < 26) begin
         packet_bytes.push_back(8'($urandom));
         packet_bytes.push_back(8'($urandom));
         packet_bytes.push_back(8'($urandom_range(1, 255)));
         packet_bytes.push_back(8'($urandom));
         add_random_bytes($urandom_range(0, 8));
      end else if (pick < 32 && chunk_total > 0) begin
         repeat ($urandom_range(1, 3)) packet_bytes.delete(packet_bytes.size() - 1);
      end
   endfunction

   task random_phase(int byte_target);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < byte_target) begin
         build_random_packet();
         send_packet();
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 18;
      recv_gap_pct = 55;
      packet_bytes = {8'hFF};
      send_packet();
      packet_bytes = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'h00, 8'h00,
                      8'hFF, 8'h00, 8'h00, 8'h04,
                      8'h00, 8'hFF, 8'h00, 8'h05, 8'hA5,
                      8'h5A, 8'h80, 8'h00, 8'h02,
                      8'h3C};
      send_packet();

      hold_asked++;
      random_phase(670);
      wait_for_drain();

      send_gap_pct = 55;
      recv_gap_pct = 18;
      random_phase(670);
      wait_for_drain();

      send_gap_pct = 0;
      recv_gap_pct = 0;
      random_phase(670);

      wait_for_drain();
      repeat (20) @(posedge clock);

      $display("tb: %0d packets, %0d bytes, %0d results checked", packets_sent,
               bytes_sent, sb.results_checked);
      $display("tb: covered too-short, truncated and bad-length packets under stalls");
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
